### src/rgb_to_nv12_converter_unit_defines.svh
// Assertion macros used by the converter's checker file.
`ifndef RGB_TO_NV12_CONVERTER_UNIT_DEFINES_SVH
`define RGB_TO_NV12_CONVERTER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define RGB2NV_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define RGB2NV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/rgb2nv_pkg.sv
// Types and constants of the RGB to NV12 converter.
package rgb2nv_pkg;

  typedef enum logic [0:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  localparam int unsigned CfgDataW = 13;

  typedef struct packed {
    logic row_odd;
    logic col_odd;
    logic last_col;
    logic last_row;
  } pix_pos_t;

  localparam logic [15:0] Y_R  = 16'd66;
  localparam logic [15:0] Y_G  = 16'd129;
  localparam logic [15:0] Y_B  = 16'd25;
  localparam logic [15:0] CB_R = 16'd38;
  localparam logic [15:0] CB_G = 16'd74;
  localparam logic [15:0] CB_B = 16'd112;
  localparam logic [15:0] CR_R = 16'd112;
  localparam logic [15:0] CR_G = 16'd94;
  localparam logic [15:0] CR_B = 16'd18;

  localparam logic [15:0] ROUND_OFS  = 16'd128;
  localparam logic [15:0] CHROMA_OFS = 16'd32896;
  localparam logic [7:0]  LUMA_BIAS  = 8'd16;

endpackage

### src/rgb_to_nv12_converter_unit.sv
// Top level of the streaming RGB to BT.601 YCbCr 4:2:0 converter.
//
// Pixels enter in raster order on the input channel (in_valid_i / in_stall_o with
// red_i, green_i, blue_i). Each accepted pixel gives one result on the output
// channel (out_valid_o / out_stall_i): its luma byte and, on the last pixel of a 2x2
// block, the averaged Cb (and Cr, where the block has two columns) of that block.
// Frame size is set through the configuration channel (cfg_valid_i, cfg_ready_o,
// cfg_index_i, cfg_data_i); write it between frames while no pixel is in flight.
// Throughput: one pixel per cycle while out_stall_i stays low. Three register
// stages (input, color, output) each hold one item; pair sums of even rows sit
// in a single-port-write, single-port-read line store, read one stage ahead of
// the write, with a bypass for a read of the entry being written on the same edge.
// Reset clears the counters, the pipeline valids and the left-hand chroma, and
// loads width 640 and height 480 (limited to the maximum sizes). The line store
// is not cleared; it is always written on an even row before the row below reads it.
// While out_stall_i holds a result, the stages behind it keep filling; the input
// stalls once all three hold an item.
module rgb_to_nv12_converter_unit import rgb2nv_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [0:0]          cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          red_i,
  input  logic [7:0]          green_i,
  input  logic [7:0]          blue_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          luma_o,
  output logic                chroma_valid_o,
  output logic [7:0]          cb_avg_o,
  output logic [7:0]          cr_avg_o,
  output logic                cr_valid_o,
  output logic                frame_end_o
);

  localparam int unsigned PairDepth = (MAX_WIDTH + 1) / 2;
  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned EWW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned EHW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned IW  = (PairDepth > 1) ? $clog2(PairDepth) : 1;
  localparam int unsigned WidthRst  = (MAX_WIDTH < 640) ? MAX_WIDTH : 640;
  localparam int unsigned HeightRst = (MAX_HEIGHT < 480) ? MAX_HEIGHT : 480;

  // configuration
  logic [EWW-1:0] width_q, width_d;
  logic [EHW-1:0] height_q, height_d;
  logic [CfgDataW:0] cfg_ext;

  assign cfg_ready_o = 1'b1;
  assign cfg_ext     = {1'b0, cfg_data_i};

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_FRAME_WIDTH: begin
          if (cfg_data_i == '0) begin
            width_d = EWW'(1);
          end else if (cfg_ext > (CfgDataW + 1)'(MAX_WIDTH)) begin
            width_d = EWW'(MAX_WIDTH);
          end else begin
            width_d = EWW'(cfg_data_i);
          end
        end
        CFG_FRAME_HEIGHT: begin
          if (cfg_data_i == '0) begin
            height_d = EHW'(1);
          end else if (cfg_ext > (CfgDataW + 1)'(MAX_HEIGHT)) begin
            height_d = EHW'(MAX_HEIGHT);
          end else begin
            height_d = EHW'(cfg_data_i);
          end
        end
        default: begin
          width_d  = width_q;
          height_d = height_q;
        end
      endcase
    end
  end

  // handshake
  logic s1_v_q, s2_v_q, out_v_q;
  logic out_ready, s2_ready, s1_ready;
  logic in_fire, s1_fire, s2_fire;

  assign out_ready  = ~out_v_q | ~out_stall_i;
  assign s2_ready   = ~s2_v_q | out_ready;
  assign s1_ready   = ~s1_v_q | s2_ready;
  assign s2_fire    = s2_v_q & out_ready;
  assign s1_fire    = s1_v_q & s2_ready;
  assign in_stall_o = ~s1_ready;
  assign in_fire    = in_valid_i & s1_ready;

  // position counters
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  pix_pos_t      pos_in;

  always_comb begin
    pos_in.row_odd  = row_q[0];
    pos_in.col_odd  = col_q[0];
    pos_in.last_col = (EWW'(col_q) + EWW'(1)) >= width_q;
    pos_in.last_row = (EHW'(row_q) + EHW'(1)) >= height_q;
    col_d = col_q;
    row_d = row_q;
    if (in_fire) begin
      if (pos_in.last_col) begin
        col_d = '0;
        row_d = pos_in.last_row ? '0 : RW'(row_q + RW'(1));
      end else begin
        col_d = CW'(col_q + CW'(1));
      end
    end
  end

  // stage 1: pixel and position
  logic [7:0]    s1_r_q, s1_g_q, s1_b_q;
  pix_pos_t      s1_pos_q;
  logic [IW-1:0] s1_idx_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_r_q   <= red_i;
      s1_g_q   <= green_i;
      s1_b_q   <= blue_i;
      s1_pos_q <= pos_in;
      s1_idx_q <= IW'(col_q >> 1);
    end
  end

  // stage 1 color conversion
  logic [15:0] y_acc, cb_acc, cr_acc;
  logic [7:0]  y_s1;

  always_comb begin
    y_acc  = 16'(s1_r_q) * Y_R + 16'(s1_g_q) * Y_G + 16'(s1_b_q) * Y_B + ROUND_OFS;
    cb_acc = 16'(s1_b_q) * CB_B + CHROMA_OFS - (16'(s1_r_q) * CB_R + 16'(s1_g_q) * CB_G);
    cr_acc = 16'(s1_r_q) * CR_R + CHROMA_OFS - (16'(s1_g_q) * CR_G + 16'(s1_b_q) * CR_B);
    y_s1   = y_acc[15:8] + LUMA_BIAS;
  end

  // stage 2: chroma averaging against the line store
  logic [7:0]    s2_y_q, s2_cb_q, s2_cr_q;
  pix_pos_t      s2_pos_q;
  logic [IW-1:0] s2_idx_q;
  logic [7:0]    left_cb_q, left_cr_q;
  logic [17:0]   pair_mem [PairDepth];
  logic [17:0]   pair_rd_q, fwd_data_q, pair_wdata, pair_old;
  logic          fwd_hit_q, pair_we;
  logic [8:0]    pair_cb, pair_cr;
  logic [9:0]    sum_cb, sum_cr, sh_cb, sh_cr;
  logic [1:0]    shift;
  logic          cvalid, crv;
  logic [7:0]    cb_avg, cr_avg;

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      s2_y_q   <= y_s1;
      s2_cb_q  <= cb_acc[15:8];
      s2_cr_q  <= cr_acc[15:8];
      s2_pos_q <= s1_pos_q;
      s2_idx_q <= s1_idx_q;
      pair_rd_q  <= pair_mem[s1_idx_q];
      fwd_data_q <= pair_wdata;
    end
    if (pair_we) begin
      pair_mem[s2_idx_q] <= pair_wdata;
    end
  end

  always_comb begin
    pair_old = fwd_hit_q ? fwd_data_q : pair_rd_q;
    pair_cb  = pair_old[8:0];
    pair_cr  = pair_old[17:9];
    if (s2_pos_q.col_odd) begin
      pair_wdata = {9'(left_cr_q) + 9'(s2_cr_q), 9'(left_cb_q) + 9'(s2_cb_q)};
    end else begin
      pair_wdata = {9'(s2_cr_q), 9'(s2_cb_q)};
    end
    pair_we = s2_fire & ~s2_pos_q.row_odd & (s2_pos_q.col_odd | s2_pos_q.last_col);

    if (!s2_pos_q.row_odd) begin
      cvalid = s2_pos_q.last_row & (s2_pos_q.col_odd | s2_pos_q.last_col);
      crv    = s2_pos_q.last_row & s2_pos_q.col_odd;
      shift  = s2_pos_q.col_odd ? 2'd1 : 2'd0;
      sum_cb = 10'(pair_wdata[8:0]);
      sum_cr = 10'(pair_wdata[17:9]);
    end else if (s2_pos_q.col_odd) begin
      cvalid = 1'b1;
      crv    = 1'b1;
      shift  = 2'd2;
      sum_cb = 10'(pair_cb) + 10'(left_cb_q) + 10'(s2_cb_q);
      sum_cr = 10'(pair_cr) + 10'(left_cr_q) + 10'(s2_cr_q);
    end else begin
      cvalid = s2_pos_q.last_col;
      crv    = 1'b0;
      shift  = 2'd1;
      sum_cb = 10'(pair_cb) + 10'(s2_cb_q);
      sum_cr = 10'(pair_cr) + 10'(s2_cr_q);
    end

    sh_cb  = sum_cb >> shift;
    sh_cr  = sum_cr >> shift;
    cb_avg = !cvalid ? 8'd0 : ((sh_cb[9:8] != 2'd0) ? 8'hFF : sh_cb[7:0]);
    cr_avg = !crv ? 8'd0 : ((sh_cr[9:8] != 2'd0) ? 8'hFF : sh_cr[7:0]);
  end

  // output register
  logic [7:0] luma_q, cb_avg_q, cr_avg_q;
  logic       chroma_valid_q, cr_valid_q, frame_end_q;

  always_ff @(posedge clk_i) begin
    if (s2_fire) begin
      luma_q         <= s2_y_q;
      chroma_valid_q <= cvalid;
      cb_avg_q       <= cb_avg;
      cr_avg_q       <= cr_avg;
      cr_valid_q     <= crv;
      frame_end_q    <= s2_pos_q.last_col & s2_pos_q.last_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= EWW'(WidthRst);
      height_q  <= EHW'(HeightRst);
      col_q     <= '0;
      row_q     <= '0;
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
      out_v_q   <= 1'b0;
      fwd_hit_q <= 1'b0;
      left_cb_q <= '0;
      left_cr_q <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
      if (s1_ready) begin
        s1_v_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_v_q <= s1_v_q;
      end
      if (out_ready) begin
        out_v_q <= s2_v_q;
      end
      if (s1_fire) begin
        fwd_hit_q <= pair_we & (s1_idx_q == s2_idx_q);
      end
      if (s2_fire && !s2_pos_q.col_odd) begin
        left_cb_q <= s2_cb_q;
        left_cr_q <= s2_cr_q;
      end
    end
  end

  assign out_valid_o    = out_v_q;
  assign luma_o         = luma_q;
  assign chroma_valid_o = chroma_valid_q;
  assign cb_avg_o       = cb_avg_q;
  assign cr_avg_o       = cr_avg_q;
  assign cr_valid_o     = cr_valid_q;
  assign frame_end_o    = frame_end_q;

endmodule

### src/rgb2nv_checker.sv
// Port checker of the RGB to NV12 converter and its bind to the top level.
`include "rgb_to_nv12_converter_unit_defines.svh"

module rgb2nv_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] luma_o,
  input logic       chroma_valid_o,
  input logic [7:0] cb_avg_o,
  input logic [7:0] cr_avg_o,
  input logic       cr_valid_o,
  input logic       frame_end_o
);

  `RGB2NV_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(luma_o) && $stable(chroma_valid_o) && $stable(cb_avg_o) && $stable(cr_avg_o) && $stable(cr_valid_o) && $stable(frame_end_o), "stalled result changed")
  `RGB2NV_ASSERT_IMPLIES(a_luma_range, out_valid_o, (luma_o >= 8'd16) && (luma_o <= 8'd235), "luma outside limited range")
  `RGB2NV_ASSERT_IMPLIES(a_no_chroma_zero, out_valid_o && !chroma_valid_o, (cb_avg_o == 8'd0) && (cr_avg_o == 8'd0) && !cr_valid_o, "chroma fields set without a block")
  `RGB2NV_ASSERT_IMPLIES(a_cr_needs_block, out_valid_o && cr_valid_o, chroma_valid_o, "cr given outside a block")

endmodule

bind rgb_to_nv12_converter_unit rgb2nv_checker u_rgb2nv_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .luma_o         (luma_o),
  .chroma_valid_o (chroma_valid_o),
  .cb_avg_o       (cb_avg_o),
  .cr_avg_o       (cr_avg_o),
  .cr_valid_o     (cr_valid_o),
  .frame_end_o    (frame_end_o)
);

### verif/tb_rgb_to_nv12_converter_unit.sv
// RGB to NV12 converter testbench: directed and random frames checked by a built-in predictor.
`timescale 1ns / 100ps

module tb_rgb_to_nv12_converter_unit import rgb2nv_pkg::*;;

  localparam int unsigned MaxDim = 4096;
  localparam int unsigned LineDepth = MaxDim / 2;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [7:0] luma;
    logic       chroma_valid;
    logic [7:0] cb_avg;
    logic [7:0] cr_avg;
    logic       cr_valid;
    logic       frame_end;
  } nv12_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [0:0]          cfg_index_i = CFG_FRAME_WIDTH;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [7:0]          red_i = '0;
  logic [7:0]          green_i = '0;
  logic [7:0]          blue_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [7:0]          luma_o;
  logic                chroma_valid_o;
  logic [7:0]          cb_avg_o;
  logic [7:0]          cr_avg_o;
  logic                cr_valid_o;
  logic                frame_end_o;

  rgb_t        rgb_pixel_q[$];
  nv12_t       nv12_expected_q[$];
  nv12_t       nv12_seen;
  int unsigned pixels_queued = 0;
  int unsigned pixels_accepted = 0;
  int unsigned mismatches = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  logic [CfgDataW-1:0] width_reg = 13'd640;
  logic [CfgDataW-1:0] height_reg = 13'd480;
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;
  int          left_cb = 0;
  int          left_cr = 0;
  int          cb_line[LineDepth];
  int          cr_line[LineDepth];

  rgb_t corner_colors[8] = '{
    '{8'h00, 8'h00, 8'h00}, '{8'hFF, 8'hFF, 8'hFF}, '{8'hFF, 8'h00, 8'h00},
    '{8'h00, 8'hFF, 8'h00}, '{8'h00, 8'h00, 8'hFF}, '{8'hFF, 8'hFF, 8'h00},
    '{8'hFF, 8'h00, 8'hFF}, '{8'h00, 8'hFF, 8'hFF}
  };

  rgb_to_nv12_converter_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .luma_o         (luma_o),
    .chroma_valid_o (chroma_valid_o),
    .cb_avg_o       (cb_avg_o),
    .cr_avg_o       (cr_avg_o),
    .cr_valid_o     (cr_valid_o),
    .frame_end_o    (frame_end_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned clamp_dim(input logic [CfgDataW-1:0] v);
    if (v == 0) return 1;
    if (v > MaxDim) return MaxDim;
    return v;
  endfunction

  function automatic int unsigned sat_byte(input int v);
    if (v < 0) return 0;
    if (v > 255) return 255;
    return v;
  endfunction

  function automatic void convert_pixel(input rgb_t px);
    int          r, g, b, cb, cr, sum_cb, sum_cr;
    int unsigned idx, shift;
    bit          last_col, last_row, cvalid, crv;
    nv12_t       res;
    r = px.red;
    g = px.green;
    b = px.blue;
    last_col = (col_pos + 1 >= clamp_dim(width_reg));
    last_row = (row_pos + 1 >= clamp_dim(height_reg));
    idx = col_pos >> 1;
    cvalid = 1'b0;
    crv = 1'b0;
    sum_cb = 0;
    sum_cr = 0;
    shift = 0;
    cb = ((-38 * r - 74 * g + 112 * b + 128) >>> 8) + 128;
    cr = ((112 * r - 94 * g - 18 * b + 128) >>> 8) + 128;
    res = '0;
    res.luma = 8'(sat_byte(((66 * r + 129 * g + 25 * b + 128) >>> 8) + 16));
    if (row_pos[0] == 1'b0) begin
      if (col_pos[0] == 1'b0) begin
        left_cb = cb;
        left_cr = cr;
        if (last_col) begin
          cb_line[idx] = cb;
          cr_line[idx] = cr;
          if (last_row) begin
            cvalid = 1'b1;
            sum_cb = cb;
            sum_cr = cr;
          end
        end
      end else begin
        cb_line[idx] = left_cb + cb;
        cr_line[idx] = left_cr + cr;
        if (last_row) begin
          cvalid = 1'b1;
          sum_cb = left_cb + cb;
          sum_cr = left_cr + cr;
          shift = 1;
          crv = 1'b1;
        end
      end
    end else begin
      if (col_pos[0] == 1'b0) begin
        left_cb = cb;
        left_cr = cr;
        if (last_col) begin
          cvalid = 1'b1;
          sum_cb = cb_line[idx] + cb;
          sum_cr = cr_line[idx] + cr;
          shift = 1;
        end
      end else begin
        cvalid = 1'b1;
        sum_cb = cb_line[idx] + left_cb + cb;
        sum_cr = cr_line[idx] + left_cr + cr;
        shift = 2;
        crv = 1'b1;
      end
    end
    res.chroma_valid = cvalid;
    res.cr_valid = crv;
    if (cvalid) res.cb_avg = 8'(sat_byte(sum_cb >>> shift));
    if (cvalid && crv) res.cr_avg = 8'(sat_byte(sum_cr >>> shift));
    res.frame_end = last_col && last_row;
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    nv12_expected_q = {nv12_expected_q, res};
  endfunction

  function automatic void check_field(input string field, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        convert_pixel('{red_i, green_i, blue_i});
        pixels_accepted++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (rgb_pixel_q.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          {red_i, green_i, blue_i} <= rgb_pixel_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (nv12_expected_q.size() == 0) begin
          $display("%0t: result with nothing pending, expected none, actual luma %0d",
                   $time, luma_o);
          mismatches++;
        end else begin
          nv12_seen = nv12_expected_q.pop_front();
          check_field("luma", nv12_seen.luma, luma_o);
          check_field("chroma_valid", nv12_seen.chroma_valid, chroma_valid_o);
          check_field("cb_avg", nv12_seen.cb_avg, cb_avg_o);
          check_field("cr_avg", nv12_seen.cr_avg, cr_avg_o);
          check_field("cr_valid", nv12_seen.cr_valid, cr_valid_o);
          check_field("frame_end", nv12_seen.frame_end, frame_end_o);
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic wait_drained();
    wait (pixels_accepted == pixels_queued && nv12_expected_q.size() == 0);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e sel, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= sel;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (sel == CFG_FRAME_WIDTH) width_reg = data;
    else height_reg = data;
  endtask

  task automatic run_frame(input logic [CfgDataW-1:0] width, input logic [CfgDataW-1:0] height,
                           input bit directed, input bit split);
    int unsigned total;
    rgb_t        px;
    wait_drained();
    write_reg(CFG_FRAME_WIDTH, width);
    write_reg(CFG_FRAME_HEIGHT, height);
    total = clamp_dim(width) * clamp_dim(height);
    for (int unsigned k = 0; k < total; k++) begin
      if (split && k == total / 2) wait_drained();
      if (directed) begin
        px = corner_colors[k % 8];
      end else begin
        px = rgb_t'($urandom);
        if ($urandom_range(5) == 0) begin
          px.red = $urandom_range(1) ? 8'hFF : 8'h00;
          px.green = $urandom_range(1) ? 8'hFF : 8'h00;
          px.blue = $urandom_range(1) ? 8'hFF : 8'h00;
        end
      end
      rgb_pixel_q = {rgb_pixel_q, px};
      pixels_queued++;
    end
  endtask

  // Stop part way into a frame, then shrink it so one more item ends the frame.
  task automatic run_cut(input logic [CfgDataW-1:0] width, input logic [CfgDataW-1:0] height,
                         input int unsigned count, input cfg_reg_e sel,
                         input logic [CfgDataW-1:0] data);
    wait_drained();
    write_reg(CFG_FRAME_WIDTH, width);
    write_reg(CFG_FRAME_HEIGHT, height);
    for (int unsigned k = 0; k < count; k++) begin
      rgb_pixel_q = {rgb_pixel_q, rgb_t'($urandom)};
      pixels_queued++;
    end
    wait_drained();
    write_reg(sel, data);
    rgb_pixel_q = {rgb_pixel_q, rgb_t'($urandom)};
    pixels_queued++;
  endtask

  initial begin
    int unsigned random_pixels;
    int unsigned frame_idx;
    logic [CfgDataW-1:0] w, h;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    run_frame(13'd3, 13'd3, 1'b1, 1'b0);
    run_frame(13'd2, 13'd2, 1'b1, 1'b0);
    run_frame(13'd0, 13'd0, 1'b1, 1'b0);
    run_frame(13'd1, 13'd2, 1'b1, 1'b0);
    run_frame(13'd2, 13'd1, 1'b1, 1'b0);
    run_frame(13'd5, 13'd1, 1'b1, 1'b0);

    random_pixels = 0;
    frame_idx = 0;
    while (random_pixels < 1300) begin
      case ((frame_idx / 5) % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin sender_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      w = 13'($urandom_range(1, 14));
      h = 13'($urandom_range(1, 9));
      run_frame(w, h, 1'b0, frame_idx % 7 == 3);
      random_pixels += w * h;
      frame_idx++;
    end

    sender_idle_pct = 25;
    recv_stall_pct = 25;
    run_cut(13'd8191, 13'd1, 40, CFG_FRAME_WIDTH, 13'd40);
    recv_stall_pct = 56;
    run_cut(13'd1, 13'd8191, 40, CFG_FRAME_HEIGHT, 13'd41);

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("rgb_to_nv12_converter_unit test passed");
    end else begin
      $display("rgb_to_nv12_converter_unit test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("rgb_to_nv12_converter_unit test failed");
    $finish;
  end

endmodule
